>>> hdl/sgt_pkg.sv
// sgt_pkg: types, codes and widths shared by the session token controller
// depends on nothing; every other file imports it
`timescale 1ns / 1ps

package sgt_pkg;

  localparam int ID_W  = 32;
  localparam int GEN_W = 32;

  typedef enum logic [2:0] {
    KIND_BEGIN          = 3'd0,
    KIND_ADMIT          = 3'd1,
    KIND_SET_INFLIGHT   = 3'd2,
    KIND_CLEAR_INFLIGHT = 3'd3,
    KIND_DRAIN          = 3'd4,
    KIND_FLUSH          = 3'd5,
    KIND_FINISH_DRAIN   = 3'd6,
    KIND_CHECK          = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ARG   = 2'd1,
    ST_STATE = 2'd2,
    ST_STALE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEPT = 2'd1,
    PH_DRAIN  = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    sess_id;
    logic [ID_W-1:0]    token_request_id;
    logic [GEN_W-1:0]   token_generation;
    logic               downstream_empty;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    issued_request_id;
    logic [GEN_W-1:0]   issued_generation;
    logic [ID_W-1:0]    closed_id;
    logic               is_current;
    phase_t             session_state;
  } res_t;

  // handshake between the command register and the result register
  typedef struct packed {
    logic fire;   // command register hands its command to the core this cycle
    logic room;   // result register can take a result this cycle
  } pipe_ctl_t;

endpackage

>>> hdl/sgt_if.sv
// sgt_cmd_if / sgt_res_if: valid-ready channels for commands and results
// depends on sgt_pkg
`timescale 1ns / 1ps

interface sgt_cmd_if;
  import sgt_pkg::*;
  logic valid;
  logic ready;
  cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sgt_res_if;
  import sgt_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/sgt_in_reg.sv
// sgt_in_reg: command register in front of the session core
// depends on sgt_pkg
`timescale 1ns / 1ps

module sgt_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sgt_pkg::cmd_t      in_cmd,
  input  logic               room,
  output sgt_pkg::pipe_ctl_t ctl,
  output sgt_pkg::cmd_t      cmd
);
  import sgt_pkg::*;

  logic cmd_v_r;
  logic cmd_v_nxt;
  cmd_t cmd_r;

  assign ctl.fire = cmd_v_r & room;
  assign ctl.room = room;
  assign in_ready = ~cmd_v_r | room;
  assign cmd      = cmd_r;

  always_comb begin
    cmd_v_nxt = cmd_v_r;
    if (in_ready) begin
      cmd_v_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
    end else begin
      cmd_v_r <= cmd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
    end
  end

endmodule

>>> hdl/sgt_core.sv
// sgt_core: session phase machine, generation counter and in-flight token
// depends on sgt_pkg
`timescale 1ns / 1ps

module sgt_core (
  input  logic               clk,
  input  logic               rst_n,
  input  sgt_pkg::pipe_ctl_t ctl,
  input  sgt_pkg::cmd_t      cmd,
  output sgt_pkg::res_t      res
);
  import sgt_pkg::*;

  localparam logic [GEN_W-1:0] GEN_ONE = {{(GEN_W-1){1'b0}}, 1'b1};

  phase_t            phase_r, phase_nxt;
  logic [ID_W-1:0]   active_id_r, active_id_nxt;
  logic [GEN_W-1:0]  gen_r, gen_nxt;
  logic              infl_r, infl_nxt;
  logic [ID_W-1:0]   infl_req_r, infl_req_nxt;
  logic [GEN_W-1:0]  infl_gen_r, infl_gen_nxt;

  logic [GEN_W-1:0]  gen_inc;
  logic [GEN_W-1:0]  gen_bumped;
  logic              rid_zero;
  logic              tok_zero;
  logic              tok_current;
  logic              tok_is_infl;

  assign gen_inc     = gen_r + GEN_ONE;
  assign gen_bumped  = (gen_inc == '0) ? GEN_ONE : gen_inc;   // wrap skips zero
  assign rid_zero    = (cmd.sess_id == '0);
  assign tok_zero    = (cmd.token_request_id == '0) || (cmd.token_generation == '0);
  assign tok_current = !tok_zero && (phase_r != PH_IDLE) &&
                       (active_id_r == cmd.token_request_id) &&
                       (gen_r == cmd.token_generation);
  assign tok_is_infl = infl_r && (infl_req_r == cmd.token_request_id) &&
                       (infl_gen_r == cmd.token_generation);

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    active_id_nxt = active_id_r;
    gen_nxt       = gen_r;
    infl_nxt      = infl_r;
    infl_req_nxt  = infl_req_r;
    infl_gen_nxt  = infl_gen_r;
    case (cmd.kind)
      KIND_BEGIN: begin
        if (!rid_zero) begin
          gen_nxt       = gen_bumped;
          active_id_nxt = cmd.sess_id;
          phase_nxt     = PH_ACCEPT;
        end
      end
      KIND_SET_INFLIGHT: begin
        if (!tok_zero && !infl_r && tok_current) begin
          infl_nxt     = 1'b1;
          infl_req_nxt = cmd.token_request_id;
          infl_gen_nxt = cmd.token_generation;
        end
      end
      KIND_CLEAR_INFLIGHT: begin
        if (!tok_zero && tok_is_infl) begin
          infl_nxt     = 1'b0;
          infl_req_nxt = '0;
          infl_gen_nxt = '0;
        end
      end
      KIND_DRAIN: begin
        if (!rid_zero && active_id_r == cmd.sess_id && phase_r != PH_IDLE) begin
          phase_nxt = PH_DRAIN;
        end
      end
      KIND_FLUSH: begin
        if (!rid_zero && (active_id_r == '0 || active_id_r == cmd.sess_id)) begin
          phase_nxt     = PH_IDLE;
          active_id_nxt = '0;
          gen_nxt       = gen_bumped;
        end
      end
      KIND_FINISH_DRAIN: begin
        if (phase_r == PH_DRAIN && cmd.downstream_empty && !infl_r) begin
          phase_nxt     = PH_IDLE;
          active_id_nxt = '0;
          gen_nxt       = gen_bumped;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields
  always_comb begin
    res                     = '0;
    res.status              = ST_OK;
    res.session_state       = phase_nxt;
    case (cmd.kind)
      KIND_BEGIN: begin
        if (rid_zero) res.status = ST_ARG;
      end
      KIND_ADMIT: begin
        if (phase_r != PH_ACCEPT || active_id_r == '0) begin
          res.status = ST_STATE;
        end else begin
          res.issued_request_id = active_id_r;
          res.issued_generation = gen_r;
        end
      end
      KIND_SET_INFLIGHT: begin
        if (tok_zero) res.status = ST_ARG;
        else if (infl_r) res.status = ST_STATE;
        else if (!tok_current) res.status = ST_STALE;
      end
      KIND_CLEAR_INFLIGHT: begin
        if (tok_zero) res.status = ST_ARG;
        else if (!tok_is_infl) res.status = ST_STALE;
      end
      KIND_DRAIN: begin
        if (rid_zero) res.status = ST_ARG;
        else if (active_id_r != cmd.sess_id || phase_r == PH_IDLE) res.status = ST_STALE;
      end
      KIND_FLUSH: begin
        if (rid_zero) res.status = ST_ARG;
        else if (active_id_r != '0 && active_id_r != cmd.sess_id) res.status = ST_STALE;
      end
      KIND_FINISH_DRAIN: begin
        if (phase_r != PH_DRAIN || !cmd.downstream_empty || infl_r) begin
          res.status = ST_STATE;
        end else begin
          res.closed_id = active_id_r;
        end
      end
      KIND_CHECK: begin
        res.is_current = tok_current;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      active_id_r <= '0;
      gen_r       <= GEN_ONE;
      infl_r      <= 1'b0;
      infl_req_r  <= '0;
      infl_gen_r  <= '0;
    end else if (ctl.fire) begin
      phase_r     <= phase_nxt;
      active_id_r <= active_id_nxt;
      gen_r       <= gen_nxt;
      infl_r      <= infl_nxt;
      infl_req_r  <= infl_req_nxt;
      infl_gen_r  <= infl_gen_nxt;
    end
  end

  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r != '0) else $error("generation counter reached zero");

  a_idle_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) == (active_id_r == '0))
    else $error("active id does not agree with idle phase");

  a_infl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !infl_r |-> (infl_req_r == '0 && infl_gen_r == '0))
    else $error("stale in-flight token left behind");

  a_begin_bumps: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && cmd.kind == KIND_BEGIN && cmd.sess_id != '0
    |=> gen_r != $past(gen_r)) else $error("begin did not advance generation");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.fire |=> $stable(gen_r) && $stable(phase_r))
    else $error("session state moved without a command");

endmodule

>>> hdl/sgt_out_reg.sv
// sgt_out_reg: result register that holds a result until the sink takes it
// depends on sgt_pkg
`timescale 1ns / 1ps

module sgt_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  sgt_pkg::pipe_ctl_t ctl,
  input  sgt_pkg::res_t      res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output sgt_pkg::res_t      out_res
);
  import sgt_pkg::*;

  logic res_v_r;
  logic res_v_nxt;
  res_t res_r;

  assign room      = ~res_v_r | out_ready;
  assign out_valid = res_v_r;
  assign out_res   = res_r;

  always_comb begin
    res_v_nxt = res_v_r;
    if (room) begin
      res_v_nxt = ctl.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      res_r <= res;
    end
  end

endmodule

>>> hdl/session_generation_token_fsm.sv
// session_generation_token_fsm: top level of the session lifecycle controller
// depends on sgt_pkg, sgt_if, sgt_in_reg, sgt_core and sgt_out_reg
//
//   channel   dir   handshake           payload
//   in_cmd    in    valid / ready       sgt_pkg::cmd_t (kind, ids, generation, downstream_empty)
//   out_res   out   valid / ready       sgt_pkg::res_t (status, token, closed id, flags)
//
// one command per cycle sustained while the sink keeps taking results; an accepted command
// passes through the command register, then the result register, which presents its result,
// computed in a single pass through sgt_core
// rst_n is synchronous, active low: idle phase, generation 1, nothing in flight, both regs empty
// a stalled result holds in the result register; the command register keeps taking a
// new transaction whenever the result register frees up in the same cycle
`timescale 1ns / 1ps

module session_generation_token_fsm (
  input  logic        clk,
  input  logic        rst_n,
  sgt_cmd_if.sink     in_cmd,
  sgt_res_if.source   out_res
);
  import sgt_pkg::*;

  pipe_ctl_t ctl;    // fire/room between the two registers
  cmd_t      cmd;    // command waiting in the command register
  res_t      res;    // result computed from it this cycle
  logic      room;   // result register can load

  // command register: a transaction lands here, the core reads it next cycle
  sgt_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_ready (in_cmd.ready),
    .in_cmd   (in_cmd.payload),
    .room     (room),
    .ctl      (ctl),
    .cmd      (cmd)
  );

  // phase machine, generation counter and in-flight token; state commits on fire
  sgt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cmd   (cmd),
    .res   (res)
  );

  // result register, loaded on fire, drained by the sink
  sgt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res       (res),
    .room      (room),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_res   (out_res.payload)
  );

endmodule
